/* src/dsps_pkg.sv */
// Shared types, constants and a helper function for the dual servo PWM sweep block.
`timescale 1ns / 1ps

package dsps_pkg;

    localparam int WIDTH_BITS  = 9;
    localparam int PERIOD_BITS = 12;
    localparam int TICK_BITS   = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX   = 9'd511;
    localparam logic [WIDTH_BITS-1:0]  CENTER      = 9'd270;
    localparam logic [PERIOD_BITS-1:0] WIDTH_BASE  = 12'd180;

    // Division by 23 as a multiplication by a scaled reciprocal, exact for 16-bit inputs.
    localparam int DIV_IN_BITS  = 16;
    localparam int DIV_SHIFT    = 21;
    localparam int DIV_MULT_BITS = 17;
    localparam logic [DIV_MULT_BITS-1:0] DIV_MULT = 17'd91181;
    localparam int DIV_PROD_BITS = DIV_IN_BITS + DIV_MULT_BITS;

    localparam logic [PERIOD_BITS-1:0] RST_PWM_PERIOD     = 12'd3600;
    localparam logic [TICK_BITS-1:0]   RST_SWEEP_INTERVAL = 16'd50000;
    localparam logic [WIDTH_BITS-1:0]  RST_SWEEP_LOW      = 9'd180;
    localparam logic [WIDTH_BITS-1:0]  RST_SWEEP_HIGH     = 9'd360;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PWM_PERIOD     = 2'd0,
        CFG_SWEEP_INTERVAL = 2'd1,
        CFG_SWEEP_LOW      = 2'd2,
        CFG_SWEEP_HIGH     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ARM_AUTO       = 2'd0,
        ARM_HORIZONTAL = 2'd1,
        ARM_VERTICAL   = 2'd2
    } t_arm;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] live_width;
        logic                  manual_mode;
        logic                  arm_select;
    } t_tick_in;

    typedef struct packed {
        logic                  pwm_horizontal;
        logic                  pwm_vertical;
        logic [WIDTH_BITS-1:0] angle_horizontal;
        logic [WIDTH_BITS-1:0] angle_vertical;
        t_arm                  active_arm;
    } t_result;

    typedef struct packed {
        logic                     valid;
        t_cfg_index               index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_write;

    function automatic logic [WIDTH_BITS-1:0] dist_from_center(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] d;
        if (w >= CENTER) begin
            d = w - CENTER;
        end else begin
            d = CENTER - w;
        end
        return d;
    endfunction

endpackage

/* src/dsps_width_map.sv */
// Maps a converter sample to a servo pulse width, sample / 23 + 180 saturated at 511.
`timescale 1ns / 1ps

module dsps_width_map #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    output logic [dsps_pkg::WIDTH_BITS-1:0]  o_width
);

    logic [dsps_pkg::DIV_IN_BITS-1:0]   sample_ext;
    logic [dsps_pkg::DIV_PROD_BITS-1:0] product;
    logic [dsps_pkg::PERIOD_BITS-1:0]   quotient;
    logic [dsps_pkg::PERIOD_BITS-1:0]   width_full;

    assign sample_ext = dsps_pkg::DIV_IN_BITS'(i_sample);
    assign product    = dsps_pkg::DIV_PROD_BITS'(sample_ext)
                      * dsps_pkg::DIV_PROD_BITS'(dsps_pkg::DIV_MULT);
    assign quotient   = product[dsps_pkg::DIV_SHIFT +: dsps_pkg::PERIOD_BITS];
    assign width_full = quotient + dsps_pkg::WIDTH_BASE;

    always_comb begin
        if (width_full > dsps_pkg::PERIOD_BITS'(dsps_pkg::WIDTH_MAX)) begin
            o_width = dsps_pkg::WIDTH_MAX;
        end else begin
            o_width = width_full[dsps_pkg::WIDTH_BITS-1:0];
        end
    end

endmodule

/* src/dsps_tick_core.sv */
// Configuration registers, period and sweep counters, held widths and the per-tick result.
`timescale 1ns / 1ps

module dsps_tick_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsps_pkg::t_cfg_write i_cfg,
    input  logic                 i_advance,
    input  dsps_pkg::t_tick_in   i_tick,
    output dsps_pkg::t_result    o_result
);

    logic [dsps_pkg::PERIOD_BITS-1:0] r_pwm_period;
    logic [dsps_pkg::TICK_BITS-1:0]   r_sweep_interval;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_sweep_low;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_sweep_high;

    logic [dsps_pkg::PERIOD_BITS-1:0] r_period_count, n_period_count;
    logic [dsps_pkg::TICK_BITS-1:0]   r_tick_count, n_tick_count;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_sweep_width, n_sweep_width;
    logic                             r_descending, n_descending;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_held_h, n_held_h;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_held_v, n_held_v;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_angle_h, n_angle_h;
    logic [dsps_pkg::WIDTH_BITS-1:0]  r_angle_v, n_angle_v;

    logic [dsps_pkg::PERIOD_BITS-1:0] pc;
    logic [dsps_pkg::TICK_BITS-1:0]   tc;
    logic [dsps_pkg::WIDTH_BITS-1:0]  width_h;
    logic [dsps_pkg::WIDTH_BITS-1:0]  width_v;
    logic [dsps_pkg::WIDTH_BITS-1:0]  live_angle;
    logic [dsps_pkg::WIDTH_BITS-1:0]  sweep_angle;
    dsps_pkg::t_arm                   arm;

    assign live_angle  = dsps_pkg::dist_from_center(i_tick.live_width);
    assign sweep_angle = dsps_pkg::dist_from_center(r_sweep_width);

    always_comb begin
        pc = r_period_count;
        tc = r_tick_count;
        if (r_pwm_period != '0 && pc >= r_pwm_period) begin
            pc = '0;
        end
        if (r_sweep_interval != '0 && tc >= r_sweep_interval) begin
            tc = '0;
        end

        n_sweep_width = r_sweep_width;
        n_descending  = r_descending;
        n_held_h      = r_held_h;
        n_held_v      = r_held_v;
        n_angle_h     = r_angle_h;
        n_angle_v     = r_angle_v;

        if (i_tick.manual_mode) begin
            if (i_tick.arm_select) begin
                n_held_h  = i_tick.live_width;
                n_angle_h = live_angle;
                arm       = dsps_pkg::ARM_HORIZONTAL;
            end else begin
                n_held_v  = i_tick.live_width;
                n_angle_v = live_angle;
                arm       = dsps_pkg::ARM_VERTICAL;
            end
            width_h = n_held_h;
            width_v = n_held_v;
        end else begin
            width_h   = r_sweep_width;
            width_v   = r_sweep_width;
            n_angle_h = sweep_angle;
            n_angle_v = sweep_angle;
            arm       = dsps_pkg::ARM_AUTO;
            if (r_sweep_width >= r_sweep_high) begin
                n_descending = 1'b1;
            end else if (r_sweep_width <= r_sweep_low) begin
                n_descending = 1'b0;
            end
            if (tc == '0) begin
                if (n_descending) begin
                    if (r_sweep_width != '0) begin
                        n_sweep_width = r_sweep_width - 1'b1;
                    end
                end else begin
                    if (r_sweep_width != dsps_pkg::WIDTH_MAX) begin
                        n_sweep_width = r_sweep_width + 1'b1;
                    end
                end
            end
        end

        n_period_count = pc + 1'b1;
        n_tick_count   = tc + 1'b1;

        o_result.pwm_horizontal   = pc < dsps_pkg::PERIOD_BITS'(width_h);
        o_result.pwm_vertical     = pc < dsps_pkg::PERIOD_BITS'(width_v);
        o_result.angle_horizontal = n_angle_h;
        o_result.angle_vertical   = n_angle_v;
        o_result.active_arm       = arm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period     <= dsps_pkg::RST_PWM_PERIOD;
            r_sweep_interval <= dsps_pkg::RST_SWEEP_INTERVAL;
            r_sweep_low      <= dsps_pkg::RST_SWEEP_LOW;
            r_sweep_high     <= dsps_pkg::RST_SWEEP_HIGH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dsps_pkg::CFG_PWM_PERIOD: begin
                    r_pwm_period <= i_cfg.data[dsps_pkg::PERIOD_BITS-1:0];
                end
                dsps_pkg::CFG_SWEEP_INTERVAL: begin
                    r_sweep_interval <= i_cfg.data[dsps_pkg::TICK_BITS-1:0];
                end
                dsps_pkg::CFG_SWEEP_LOW: begin
                    r_sweep_low <= i_cfg.data[dsps_pkg::WIDTH_BITS-1:0];
                end
                dsps_pkg::CFG_SWEEP_HIGH: begin
                    r_sweep_high <= i_cfg.data[dsps_pkg::WIDTH_BITS-1:0];
                end
                default: begin
                    r_pwm_period <= r_pwm_period;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_count <= '0;
            r_tick_count   <= '0;
            r_sweep_width  <= dsps_pkg::RST_SWEEP_LOW;
            r_descending   <= 1'b0;
            r_held_h       <= '0;
            r_held_v       <= '0;
            r_angle_h      <= '0;
            r_angle_v      <= '0;
        end else if (i_advance) begin
            r_period_count <= n_period_count;
            r_tick_count   <= n_tick_count;
            r_sweep_width  <= n_sweep_width;
            r_descending   <= n_descending;
            r_held_h       <= n_held_h;
            r_held_v       <= n_held_v;
            r_angle_h      <= n_angle_h;
            r_angle_v      <= n_angle_v;
        end
    end

endmodule

/* src/dual_servo_pwm_sweep.sv */
// Top level of the dual servo PWM generator with manual control and automatic sweep.
//
//  Channel   Direction  Handshake                     Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   one timer tick: sample, mode, arm
//  m_axis    out        m_axis_tvalid/m_axis_tready   PWM levels, angles, active arm
//  cfg       in         i_cfg_valid/o_cfg_ready       register index and write data
//
// One tick is taken per cycle unless m_axis stalls; results leave the output register.
// The width map sits before the input register and the tick logic before the output register.
// A stalled output holds its result while one more tick waits in the input register.
// Reset restores the register defaults and clears all counters and held widths.
`timescale 1ns / 1ps

module dual_servo_pwm_sweep #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // adc_sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // manual_mode, arm_select
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pwm_horizontal, pwm_vertical, angle_horizontal, angle_vertical
    output logic [23:0]                          m_axis_tdata,
    // active_arm
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dsps_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [dsps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic                         r_in_valid;
    dsps_pkg::t_tick_in           r_in_tick;
    logic                         r_out_valid;
    dsps_pkg::t_result            r_out_result;

    logic [dsps_pkg::WIDTH_BITS-1:0] live_width;
    logic                            out_ready;
    logic                            advance;
    logic                            in_take;
    dsps_pkg::t_cfg_write            cfg_write;
    dsps_pkg::t_result               result;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign cfg_write.valid = i_cfg_valid;
    assign cfg_write.index = dsps_pkg::t_cfg_index'(i_cfg_index);
    assign cfg_write.data  = i_cfg_data;

    dsps_width_map #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_width_map (
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_width  (live_width)
    );

    dsps_tick_core u_tick_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_write),
        .i_advance (advance),
        .i_tick    (r_in_tick),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tick.live_width  <= live_width;
            r_in_tick.manual_mode <= s_axis_tuser[0];
            r_in_tick.arm_select  <= s_axis_tuser[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_out_result.angle_vertical,
                            r_out_result.angle_horizontal,
                            r_out_result.pwm_vertical,
                            r_out_result.pwm_horizontal};
    assign m_axis_tuser  = r_out_result.active_arm;

endmodule
